FILE: src/wsli_pkg.sv
// Shared types and codes for the window seed list.
package wsli_pkg;

    typedef enum logic [1:0] {
        F_INSERT = 2'd0,
        F_CLEAR  = 2'd1,
        F_READ   = 2'd2,
        F_NOP    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        C_HOLD,
        C_INS_UP,
        C_INS_GE,
        C_REMOVE,
        C_COMPACT,
        C_MIN_INIT,
        C_MIN_BIT
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_REPL,
        S_MIN,
        S_COMPACT,
        S_INS_GE,
        S_DONE
    } t_state;

    typedef struct packed {
        t_cell_op   op;
        logic [3:0] bit_sel;
        logic       zero_any;
    } t_cell_ctrl;

endpackage

FILE: src/wsli_cell.sv
// One list position: stored seed, compare logic and neighbour hand-off.
module wsli_cell #(
    parameter int R = 12
) (
    input  logic                  i_clk,
    input  wsli_pkg::t_cell_ctrl  i_ctrl,
    input  logic [58+2*R:0]       i_seed,
    input  logic [58+2*R:0]       i_left,
    input  logic [58+2*R:0]       i_right,
    input  logic                  i_right_cand,
    input  logic                  i_occ,
    input  logic                  i_prev_ov,
    input  logic                  i_prev_b,
    input  logic                  i_prev_kill,
    input  logic                  i_prev_zero,
    output logic [58+2*R:0]       o_entry,
    output logic                  o_cand,
    output logic                  o_ov,
    output logic                  o_b,
    output logic                  o_kill,
    output logic                  o_zero,
    output logic                  o_hit,
    output logic                  o_longer
);
    import wsli_pkg::*;

    localparam int RS = 40;
    localparam int LN = 40 + R;
    localparam int AN = 40 + 2*R;
    localparam int JN = 41 + 2*R;

    logic [58+2*R:0] r_entry;
    logic            r_cand;

    logic [39:0] e_g, s_g;
    logic [R-1:0] e_rs, e_len, s_rs, s_len;
    logic [15:0] e_jn, s_jn;
    logic        e_anc;
    logic [R:0]  e_end, s_end;
    logic        ov, first;

    assign e_g   = r_entry[39:0];
    assign e_rs  = r_entry[RS +: R];
    assign e_len = r_entry[LN +: R];
    assign e_anc = r_entry[AN];
    assign e_jn  = r_entry[JN +: 16];
    assign s_g   = i_seed[39:0];
    assign s_rs  = i_seed[RS +: R];
    assign s_len = i_seed[LN +: R];
    assign s_jn  = i_seed[JN +: 16];

    assign e_end = {1'b0, e_rs} + {1'b0, e_len};
    assign s_end = {1'b0, s_rs} + {1'b0, s_len};

    always_comb begin
        ov = i_occ && (e_jn == s_jn)
            && (({1'b0, s_g} + 41'(e_rs)) == ({1'b0, e_g} + 41'(s_rs)))
            && ((({1'b0, s_rs} >= {1'b0, e_rs}) && ({1'b0, s_rs} < e_end))
                || ((s_end > {1'b0, e_rs}) && (s_end <= e_end)));
        first = ov && !i_prev_ov;
    end

    assign o_ov     = i_prev_ov || ov;
    assign o_hit    = first && (s_g == e_g) && (s_len == e_len);
    assign o_longer = first && (s_len > e_len);
    assign o_b      = !i_occ || ((i_ctrl.op == C_INS_GE) ? (e_rs >= s_rs) : (e_rs > s_rs));
    assign o_kill   = i_prev_kill || r_cand;
    assign o_zero   = i_prev_zero || (r_cand && !e_len[i_ctrl.bit_sel[$clog2(R)-1:0]]);
    assign o_entry  = r_entry;
    assign o_cand   = r_cand;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            C_INS_UP, C_INS_GE: begin
                if (i_prev_b) begin
                    r_entry <= i_left;
                end else if (o_b) begin
                    r_entry <= i_seed;
                end
            end
            C_REMOVE: begin
                if (o_ov) r_entry <= i_right;
            end
            C_COMPACT: begin
                if (o_kill) begin
                    r_entry <= i_right;
                    r_cand  <= i_right_cand;
                end
            end
            C_MIN_INIT: r_cand <= i_occ && !e_anc;
            C_MIN_BIT: begin
                if (i_ctrl.zero_any && e_len[i_ctrl.bit_sel[$clog2(R)-1:0]]) r_cand <= 1'b0;
            end
            default: ;
        endcase
    end

endmodule

FILE: src/window_seed_list_insert.sv
// Top level: sorted seed list of one alignment window, a chain of list cells.
//  channel | direction | tdata / tuser
//  s       | in        | seed and entry index / func
//  m       | out       | accepted, counts, entry read
//  cfg     | in        | max_seeds write
// Read, clear, no-op and plain insert pass through the execute and done states.
// Replacement adds a replace state; a full list adds a bit-serial minimum
// search over READ_POS_BITS bits, one compaction step per removed seed and
// a closing insert; a full list holding only anchors ends after the search.
// Reset clears counts, threshold and control; stored seeds are not cleared.
// A result waits in the output register; a new transfer is taken meanwhile.
module window_seed_list_insert #(
    parameter int MAX_SEEDS     = 64,
    parameter int READ_POS_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // genome_start, read_start, seed_length, is_anchor, junction_id,
    // strand_dir, mate_index, entry_index
    input  logic [((65+2*READ_POS_BITS+7)/8)*8-1:0] i_s_tdata,
    // func
    input  logic [1:0]                             i_s_tuser,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // accepted, seed_count, anchor_count, out_genome_start, out_read_start,
    // out_length, out_anchor, out_junction, out_dir, out_mate
    output logic [((74+2*READ_POS_BITS+7)/8)*8-1:0] o_m_tdata,
    input  logic                                   i_cfg_we,
    input  logic [6:0]                             i_cfg_wdata
);
    import wsli_pkg::*;

    localparam int R   = READ_POS_BITS;
    localparam int EW  = 59 + 2*R;
    localparam int OW  = ((74+2*R+7)/8)*8;
    localparam int CW  = $clog2(MAX_SEEDS+1);
    localparam int KW  = (CW > 7) ? CW : 7;
    localparam int IW  = $clog2(MAX_SEEDS);
    localparam int XW  = (IW > 6) ? IW : 6;
    localparam int LN  = 40 + R;
    localparam int AN  = 40 + 2*R;

    t_state         r_state, n_state;
    logic [6:0]     r_max, r_anch, n_anch;
    logic [CW-1:0]  r_count, n_count;
    logic [R:0]     r_thr, n_thr;
    logic [R-1:0]   r_min, n_min;
    logic [3:0]     r_bit, n_bit;
    logic [EW-1:0]  r_seed;
    logic [5:0]     r_idx;
    t_func          r_func;
    logic           r_acc, n_acc;
    logic [EW-1:0]  r_rd, n_rd;
    logic           r_o_valid;
    logic [OW-1:0]  r_o_data;
    t_cell_ctrl     ctrl;

    logic [EW-1:0]  c_ent [MAX_SEEDS];
    logic           c_cand[MAX_SEEDS];
    logic           c_ov  [MAX_SEEDS];
    logic           c_b   [MAX_SEEDS];
    logic           c_kill[MAX_SEEDS];
    logic           c_zero[MAX_SEEDS];
    logic [MAX_SEEDS-1:0] c_hit, c_longer;

    logic [KW-1:0]  cap;
    logic [XW-1:0]  idx_x;
    logic           ov_any, hit_any, longer_any, cand_any, s_anc;
    logic [R-1:0]   s_len;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SEEDS; gi++) begin : g_cell
            wsli_cell #(.R(R)) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_seed       (r_seed),
                .i_left       ((gi == 0) ? r_seed : c_ent[(gi == 0) ? 0 : gi-1]),
                .i_right      ((gi == MAX_SEEDS-1) ? c_ent[gi]
                               : c_ent[(gi == MAX_SEEDS-1) ? gi : gi+1]),
                .i_right_cand ((gi == MAX_SEEDS-1) ? 1'b0
                               : c_cand[(gi == MAX_SEEDS-1) ? gi : gi+1]),
                .i_occ        (CW'(gi) < r_count),
                .i_prev_ov    ((gi == 0) ? 1'b0 : c_ov  [(gi == 0) ? 0 : gi-1]),
                .i_prev_b     ((gi == 0) ? 1'b0 : c_b   [(gi == 0) ? 0 : gi-1]),
                .i_prev_kill  ((gi == 0) ? 1'b0 : c_kill[(gi == 0) ? 0 : gi-1]),
                .i_prev_zero  ((gi == 0) ? 1'b0 : c_zero[(gi == 0) ? 0 : gi-1]),
                .o_entry      (c_ent[gi]),
                .o_cand       (c_cand[gi]),
                .o_ov         (c_ov[gi]),
                .o_b          (c_b[gi]),
                .o_kill       (c_kill[gi]),
                .o_zero       (c_zero[gi]),
                .o_hit        (c_hit[gi]),
                .o_longer     (c_longer[gi])
            );
        end
    endgenerate

    assign ov_any     = c_ov[MAX_SEEDS-1];
    assign cand_any   = c_kill[MAX_SEEDS-1];
    assign hit_any    = |c_hit;
    assign longer_any = |c_longer;
    assign s_anc      = r_seed[AN];
    assign s_len      = r_seed[LN +: R];
    assign idx_x      = XW'(r_idx);

    always_comb begin
        if (r_max == 7'd0) begin
            cap = KW'(1);
        end else if (KW'(r_max) > KW'(MAX_SEEDS)) begin
            cap = KW'(MAX_SEEDS);
        end else begin
            cap = KW'(r_max);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_anch        = r_anch;
        n_thr         = r_thr;
        n_min         = r_min;
        n_bit         = r_bit;
        n_acc         = r_acc;
        n_rd          = r_rd;
        ctrl.op       = C_HOLD;
        ctrl.bit_sel  = r_bit;
        ctrl.zero_any = c_zero[MAX_SEEDS-1];
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_acc   = 1'b0;
                n_rd    = '0;
                n_state = S_DONE;
                unique case (r_func)
                    F_CLEAR: begin
                        n_count = '0;
                        n_anch  = '0;
                        n_thr   = '0;
                    end
                    F_READ: begin
                        if (KW'(idx_x) < KW'(r_count)) begin
                            n_rd = c_ent[idx_x[IW-1:0]];
                        end
                    end
                    F_INSERT: begin
                        if (!s_anc && {1'b0, s_len} <= r_thr) begin
                            n_acc = 1'b0;
                        end else if (ov_any) begin
                            if (!hit_any && longer_any) begin
                                ctrl.op = C_REMOVE;
                                n_count = r_count - CW'(1);
                                n_state = S_REPL;
                            end
                        end else begin
                            if (s_anc && r_anch < 7'd127) n_anch = r_anch + 7'd1;
                            if (KW'(r_count) >= cap) begin
                                ctrl.op = C_MIN_INIT;
                                n_bit   = 4'(R-1);
                                n_state = S_MIN;
                            end else begin
                                ctrl.op = C_INS_UP;
                                n_count = r_count + CW'(1);
                                n_acc   = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_REPL: begin
                ctrl.op = C_INS_UP;
                n_count = r_count + CW'(1);
                n_acc   = 1'b1;
                n_state = S_DONE;
            end
            S_MIN: begin
                if (!cand_any) begin
                    n_thr   = (R+1)'(1) << R;
                    n_state = S_DONE;
                end else begin
                    ctrl.op = C_MIN_BIT;
                    n_min[r_bit[$clog2(R)-1:0]] = !c_zero[MAX_SEEDS-1];
                    n_bit = r_bit - 4'd1;
                    if (r_bit == 4'd0) begin
                        n_thr   = {1'b0, n_min};
                        n_state = S_COMPACT;
                    end
                end
            end
            S_COMPACT: begin
                if (cand_any) begin
                    ctrl.op = C_COMPACT;
                    n_count = r_count - CW'(1);
                end else begin
                    n_state = S_INS_GE;
                end
            end
            S_INS_GE: begin
                n_state = S_DONE;
                if (!(!s_anc && r_min >= s_len) && KW'(r_count) < cap) begin
                    ctrl.op = C_INS_GE;
                    n_count = r_count + CW'(1);
                    n_acc   = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_m_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_anch    <= '0;
            r_thr     <= '0;
            r_max     <= 7'd50;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_anch  <= n_anch;
            r_thr   <= n_thr;
            if (i_cfg_we) r_max <= i_cfg_wdata;
            if (r_state == S_DONE && (!r_o_valid || i_m_tready)) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_min <= n_min;
        r_bit <= n_bit;
        r_acc <= n_acc;
        r_rd  <= n_rd;
        if (r_state == S_IDLE && i_s_tvalid) begin
            r_seed <= i_s_tdata[EW-1:0];
            r_idx  <= i_s_tdata[EW +: 6];
            r_func <= t_func'(i_s_tuser);
        end
        if (r_state == S_DONE && (!r_o_valid || i_m_tready)) begin
            r_o_data <= OW'({r_rd, r_anch, 7'(r_count), r_acc});
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        KW'(r_count) <= KW'(MAX_SEEDS))
        else $error("seed count above list depth");

    a_anch_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_anch < $past(r_anch)) |-> ($past(r_func) == F_CLEAR))
        else $error("anchor count fell without a clear");

    a_min_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIN) |=> (r_count == $past(r_count)))
        else $error("list length changed during minimum search");
`endif

endmodule
